/* hdl/dss_pkg.sv */
// Shared types and constants of the disk seek scheduler.
package dss_pkg;

	localparam int HEAD_W = 16;
	localparam int SEEK_W = 21;
	localparam int CFG_W  = 16;

	localparam logic [1:0] REG_MODE  = 2'd0;
	localparam logic [1:0] REG_START = 2'd1;
	localparam logic [1:0] REG_END   = 2'd2;

	localparam logic [1:0] MODE_FCFS  = 2'd0;
	localparam logic [1:0] MODE_SCAN  = 2'd1;
	localparam logic [1:0] MODE_CSCAN = 2'd2;

	typedef enum logic [1:0] {
		TGT_MEM,
		TGT_BEST,
		TGT_END,
		TGT_ZERO
	} tgt_sel_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_PREP,
		S_FC_RD,
		S_FC_DRAIN,
		S_UP_SRCH,
		S_UP_DRAIN,
		S_UP_DEC,
		S_LO_SRCH,
		S_LO_DRAIN,
		S_LO_DEC,
		S_JUMP,
		S_FINISH
	} state_t;

	typedef struct packed {
		logic     store;
		logic     prep;
		logic     rd_en;
		logic     srch_clr;
		logic     cmp_en;
		logic     desc;
		logic     lower;
		logic     emit;
		tgt_sel_t tgt;
		logic     bound_clr;
		logic     flush;
	} cmd_t;

	typedef struct packed {
		logic [1:0] mode;
		logic       found;
		logic       bound_valid;
	} sts_t;

endpackage

/* hdl/disk_seek_scheduler_top.sv */
// Top level of the disk seek scheduler: controller and datapath.
//
// Channel   Direction  Handshake              Word
// request   in         start & !busy          request_cylinder, last_request
// result    out        result_valid strobe    head_stop, seek_total, final_stop, dropped_flag
// config    in         cfg_valid & cfg_ready  cfg_index, cfg_data
//
// A request that is not marked last is taken and busy stays low.
// After the last request, first come first serve reads the stored requests once, in order.
// Scan and circular scan make passes over the single-port request memory: one pass per
// stop plus one that finds the lower group exhausted, and circular scan adds a step for the
// jump to cylinder zero.
// Reset clears the batch and sets the registers to mode 0, start 0, end all ones.
// Results are strobed for one cycle each and cannot be held off.
module disk_seek_scheduler_top import dss_pkg::*; #(
	parameter int MAX_REQUESTS  = 16,
	parameter int CYLINDER_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [HEAD_W-1:0] request_cylinder,
	input  logic              last_request,
	output logic              result_valid,
	output logic [HEAD_W-1:0] head_stop,
	output logic [SEEK_W-1:0] seek_total,
	output logic              final_stop,
	output logic              dropped_flag,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic [CFG_W-1:0]  cfg_data
);

	localparam int IW  = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
	localparam int CNW = $clog2(MAX_REQUESTS + 1);

	cmd_t           cmd;
	sts_t           sts;
	logic [IW-1:0]  rd_addr;
	logic [CNW-1:0] count;

	assign cfg_ready = 1'b1;

	dss_ctrl #(
		.MAX_REQUESTS(MAX_REQUESTS)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.last_request(last_request),
		.busy        (busy),
		.count       (count),
		.sts         (sts),
		.cmd         (cmd),
		.rd_addr     (rd_addr)
	);

	dss_datapath #(
		.MAX_REQUESTS (MAX_REQUESTS),
		.CYLINDER_BITS(CYLINDER_BITS)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_valid && cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.request_cylinder(request_cylinder),
		.cmd             (cmd),
		.rd_addr         (rd_addr),
		.count           (count),
		.sts             (sts),
		.result_valid    (result_valid),
		.head_stop       (head_stop),
		.seek_total      (seek_total),
		.final_stop      (final_stop),
		.dropped_flag    (dropped_flag)
	);

endmodule

/* hdl/dss_ctrl.sv */
// Controller state machine of the disk seek scheduler.
module dss_ctrl import dss_pkg::*; #(
	parameter int MAX_REQUESTS = 16,
	localparam int IW  = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1,
	localparam int CNW = $clog2(MAX_REQUESTS + 1)
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic           last_request,
	output logic           busy,
	input  logic [CNW-1:0] count,
	input  sts_t           sts,
	output cmd_t           cmd,
	output logic [IW-1:0]  rd_addr
);

	state_t          state_q, state_d;
	logic [IW-1:0]   idx_q, idx_d;
	logic            idx_last;
	logic            lo_phase;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
		end
	end

	assign idx_last = (CNW'(idx_q) + CNW'(1)) == count;
	assign lo_phase = (state_q == S_LO_SRCH) || (state_q == S_LO_DRAIN);
	assign busy     = state_q != S_IDLE;
	assign rd_addr  = idx_q;

	always_comb begin
		state_d = state_q;
		idx_d   = idx_q;
		cmd     = '0;
		cmd.tgt = TGT_MEM;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.store = 1'b1;
					if (last_request) state_d = S_PREP;
				end
			end
			S_PREP: begin
				cmd.prep = 1'b1;
				idx_d    = '0;
				if (sts.mode == MODE_SCAN || sts.mode == MODE_CSCAN)
					state_d = S_UP_SRCH;
				else
					state_d = S_FC_RD;
			end
			S_FC_RD: begin
				// The word read in the previous cycle is served now.
				cmd.rd_en = 1'b1;
				cmd.emit  = idx_q != '0;
				if (idx_last) begin
					idx_d   = '0;
					state_d = S_FC_DRAIN;
				end else begin
					idx_d = idx_q + 1'b1;
				end
			end
			S_FC_DRAIN: begin
				cmd.emit = 1'b1;
				state_d  = S_FINISH;
			end
			S_UP_SRCH, S_LO_SRCH: begin
				cmd.rd_en    = 1'b1;
				cmd.srch_clr = idx_q == '0;
				cmd.cmp_en   = idx_q != '0;
				cmd.lower    = lo_phase;
				cmd.desc     = lo_phase && (sts.mode == MODE_SCAN);
				if (idx_last) begin
					idx_d   = '0;
					state_d = lo_phase ? S_LO_DRAIN : S_UP_DRAIN;
				end else begin
					idx_d = idx_q + 1'b1;
				end
			end
			S_UP_DRAIN, S_LO_DRAIN: begin
				cmd.cmp_en = 1'b1;
				cmd.lower  = lo_phase;
				cmd.desc   = lo_phase && (sts.mode == MODE_SCAN);
				state_d    = lo_phase ? S_LO_DEC : S_UP_DEC;
			end
			S_UP_DEC: begin
				cmd.emit = 1'b1;
				if (sts.found) begin
					cmd.tgt = TGT_BEST;
					state_d = S_UP_SRCH;
				end else begin
					cmd.tgt       = TGT_END;
					cmd.bound_clr = 1'b1;
					state_d       = S_LO_SRCH;
				end
			end
			S_LO_DEC: begin
				if (sts.found) begin
					cmd.emit = 1'b1;
					// Circular scan returns to cylinder zero before the lower group.
					if (sts.mode == MODE_CSCAN && !sts.bound_valid) begin
						cmd.tgt = TGT_ZERO;
						state_d = S_JUMP;
					end else begin
						cmd.tgt = TGT_BEST;
						state_d = S_LO_SRCH;
					end
				end else begin
					state_d = S_FINISH;
				end
			end
			S_JUMP: begin
				cmd.emit = 1'b1;
				cmd.tgt  = TGT_BEST;
				state_d  = S_LO_SRCH;
			end
			S_FINISH: begin
				cmd.flush = 1'b1;
				state_d   = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

/* hdl/dss_datapath.sv */
// Datapath of the disk seek scheduler: request memory, search, seek total and result words.
module dss_datapath import dss_pkg::*; #(
	parameter int MAX_REQUESTS  = 16,
	parameter int CYLINDER_BITS = 16,
	localparam int IW  = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1,
	localparam int CNW = $clog2(MAX_REQUESTS + 1),
	localparam int CW  = (CYLINDER_BITS < HEAD_W) ? CYLINDER_BITS : HEAD_W
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [CFG_W-1:0]  cfg_data,
	input  logic [HEAD_W-1:0] request_cylinder,
	input  cmd_t              cmd,
	input  logic [IW-1:0]     rd_addr,
	output logic [CNW-1:0]    count,
	output sts_t              sts,
	output logic              result_valid,
	output logic [HEAD_W-1:0] head_stop,
	output logic [SEEK_W-1:0] seek_total,
	output logic              final_stop,
	output logic              dropped_flag
);

	logic [CW-1:0]     mem [MAX_REQUESTS];
	logic [1:0]        mode_q;
	logic [CW-1:0]     start_q, end_q;
	logic [CNW-1:0]    count_q;
	logic              overflow_q;
	logic              room;

	logic [CW-1:0]     rd_data_s1;
	logic [IW-1:0]     rd_idx_s1;

	logic              best_found_q, bound_valid_q;
	logic [CW-1:0]     best_v_q, bound_v_q;
	logic [IW-1:0]     best_i_q, bound_i_q;
	logic              grp_ok, bnd_ok, better, take;

	logic [CW-1:0]     pos_q, target, move_len;
	logic [SEEK_W-1:0] seek_q, seek_next;
	logic [SEEK_W:0]   seek_sum;

	logic              pend_valid_q;
	logic [CW-1:0]     pend_stop_q;
	logic [SEEK_W-1:0] pend_seek_q;
	logic              res_valid_q, final_q, dropped_q;
	logic [HEAD_W-1:0] head_q;
	logic [SEEK_W-1:0] seek_out_q;

	assign room  = count_q < CNW'(MAX_REQUESTS);
	assign count = count_q;
	assign sts   = '{mode: mode_q, found: best_found_q, bound_valid: bound_valid_q};

	always_ff @(posedge clk) begin
		if (cmd.store && room) mem[count_q[IW-1:0]] <= request_cylinder[CW-1:0];
		if (cmd.rd_en) begin
			rd_data_s1 <= mem[rd_addr];
			rd_idx_s1  <= rd_addr;
		end
	end

	// Search keys are (cylinder, index); ties keep arrival order, reversed if descending.
	always_comb begin
		grp_ok = cmd.lower ? (rd_data_s1 <= start_q) : (rd_data_s1 > start_q);
		if (!bound_valid_q)
			bnd_ok = 1'b1;
		else if (cmd.desc)
			bnd_ok = (rd_data_s1 < bound_v_q) ||
				(rd_data_s1 == bound_v_q && rd_idx_s1 < bound_i_q);
		else
			bnd_ok = (rd_data_s1 > bound_v_q) ||
				(rd_data_s1 == bound_v_q && rd_idx_s1 > bound_i_q);
		if (!best_found_q)
			better = 1'b1;
		else if (cmd.desc)
			better = rd_data_s1 >= best_v_q;
		else
			better = rd_data_s1 < best_v_q;
		take = cmd.cmp_en && grp_ok && bnd_ok && better;
	end

	always_comb begin
		case (cmd.tgt)
			TGT_MEM:  target = rd_data_s1;
			TGT_BEST: target = best_v_q;
			TGT_END:  target = end_q;
			TGT_ZERO: target = '0;
			default:  target = '0;
		endcase
		move_len  = (target >= pos_q) ? (target - pos_q) : (pos_q - target);
		seek_sum  = {1'b0, seek_q} + (SEEK_W + 1)'(move_len);
		seek_next = seek_sum[SEEK_W] ? '1 : seek_sum[SEEK_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q        <= MODE_FCFS;
			start_q       <= '0;
			end_q         <= '1;
			count_q       <= '0;
			overflow_q    <= 1'b0;
			best_found_q  <= 1'b0;
			bound_valid_q <= 1'b0;
			pend_valid_q  <= 1'b0;
			res_valid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_MODE:  mode_q  <= cfg_data[1:0];
					REG_START: start_q <= cfg_data[CW-1:0];
					REG_END:   end_q   <= cfg_data[CW-1:0];
					default:   ;
				endcase
			end
			if (cmd.store) begin
				if (room) count_q <= count_q + 1'b1;
				else overflow_q <= 1'b1;
			end
			if (cmd.srch_clr) best_found_q <= 1'b0;
			else if (take) best_found_q <= 1'b1;
			if (cmd.prep || cmd.bound_clr) bound_valid_q <= 1'b0;
			else if (cmd.emit && cmd.tgt == TGT_BEST) bound_valid_q <= 1'b1;
			res_valid_q <= (cmd.emit || cmd.flush) && pend_valid_q;
			if (cmd.prep || cmd.flush) pend_valid_q <= 1'b0;
			else if (cmd.emit) pend_valid_q <= 1'b1;
			if (cmd.flush) begin
				count_q    <= '0;
				overflow_q <= 1'b0;
			end
		end
	end

	// One stop is held back so the last one can be marked final.
	always_ff @(posedge clk) begin
		if (take) begin
			best_v_q <= rd_data_s1;
			best_i_q <= rd_idx_s1;
		end
		if (cmd.emit && cmd.tgt == TGT_BEST) begin
			bound_v_q <= best_v_q;
			bound_i_q <= best_i_q;
		end
		if (cmd.prep) begin
			pos_q  <= start_q;
			seek_q <= '0;
		end else if (cmd.emit) begin
			pos_q       <= target;
			seek_q      <= seek_next;
			pend_stop_q <= target;
			pend_seek_q <= seek_next;
		end
		if ((cmd.emit || cmd.flush) && pend_valid_q) begin
			head_q     <= HEAD_W'(pend_stop_q);
			seek_out_q <= pend_seek_q;
			final_q    <= cmd.flush;
			dropped_q  <= overflow_q;
		end
	end

	assign result_valid = res_valid_q;
	assign head_stop    = head_q;
	assign seek_total   = seek_out_q;
	assign final_stop   = final_q;
	assign dropped_flag = dropped_q;

endmodule
